>>> rtl/assert_macros.svh
// assertion macros shared by the rtl of the subset construction block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define NSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define NSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/nsc_pkg.sv
// shared types and constants of the subset construction block
`default_nettype none

package nsc_pkg;

  // default sizes of the stores
  localparam int MAX_NFA_STATES_DEF = 8;
  localparam int MAX_SYMBOLS_DEF    = 4;
  localparam int MAX_DFA_STATES_DEF = 256;

  // fixed port widths
  localparam int MASK_W     = 8;
  localparam int ROW_IDX_W  = 8;
  localparam int OP_W       = 2;
  localparam int FROM_W     = 3;
  localparam int SYM_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int OUT_SYMS   = 4;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_BEGIN  = 2'd1,
    OP_EXPAND = 2'd2,
    OP_NOP    = 2'd3
  } nsc_op_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_INDEX  = 2'd2;

  // reset values of the configuration registers
  localparam logic [3:0] STATE_COUNT_RST  = 4'd8;
  localparam logic [2:0] SYMBOL_COUNT_RST = 3'd4;
  localparam logic [2:0] START_INDEX_RST  = 3'd0;

  // control of the row accumulator
  typedef struct packed {
    logic clear;   // empty the accumulator
    logic issue;   // a row read is issued this cycle
    logic member;  // the issued row belongs to the source subset
  } acc_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/nsc_row_unit.sv
// nfa row memory with the shared or-accumulator
`default_nettype none
`include "assert_macros.svh"

module nsc_row_unit #(
  parameter int SET_W  = 8,
  parameter int ADDR_W = 5
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire logic [ADDR_W-1:0]   wr_addr_i,
  input  wire logic [SET_W-1:0]    wr_data_i,
  input  wire logic [ADDR_W-1:0]   rd_addr_i,
  input  wire nsc_pkg::acc_ctrl_t  ctrl_i,
  output logic      [SET_W-1:0]    acc_o
);
  import nsc_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [SET_W-1:0] mem [DEPTH];
  logic [SET_W-1:0] rd_data_q;
  logic             take_q;
  logic [SET_W-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  // in the cycle after the read: or in the row if its state is a member
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      take_q <= ctrl_i.issue & ctrl_i.member;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (take_q) begin
        acc_q <= acc_q | rd_data_q;
      end
    end
  end

  assign acc_o = acc_q;

  `NSC_ASSERT(a_take_follows_issue, take_q |-> $past(ctrl_i.issue), "row taken without a read")
  `NSC_ASSERT(a_no_clear_while_take, ctrl_i.clear |-> !take_q, "accumulator cleared mid-gather")

endmodule

`default_nettype wire

>>> rtl/nsc_set_store.sv
// found-subset list and the subset-to-index map
`default_nettype none

module nsc_set_store #(
  parameter int SET_W = 8,
  parameter int IDX_W = 8,
  parameter int DEPTH = 256
) (
  input  wire logic             clk_i,
  input  wire logic             fs_we_i,
  input  wire logic [IDX_W-1:0] fs_waddr_i,
  input  wire logic [SET_W-1:0] fs_wdata_i,
  input  wire logic [IDX_W-1:0] fs_raddr_i,
  output logic      [SET_W-1:0] fs_rdata_o,
  input  wire logic             sm_we_i,
  input  wire logic [SET_W-1:0] sm_waddr_i,
  input  wire logic [IDX_W-1:0] sm_wdata_i,
  input  wire logic [SET_W-1:0] sm_raddr_i,
  output logic      [IDX_W-1:0] sm_rdata_o
);

  localparam int MAP_DEPTH = 1 << SET_W;

  // subsets in discovery order
  logic [SET_W-1:0] found_sets [DEPTH];
  // index of a subset in found_sets; trusted only when that entry points back
  logic [IDX_W-1:0] seen_map [MAP_DEPTH];

  always_ff @(posedge clk_i) begin
    if (fs_we_i) begin
      found_sets[fs_waddr_i] <= fs_wdata_i;
    end
    fs_rdata_o <= found_sets[fs_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (sm_we_i) begin
      seen_map[sm_waddr_i] <= sm_wdata_i;
    end
    sm_rdata_o <= seen_map[sm_raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/nfa_subset_construction.sv
// top level of the nfa to dfa subset construction block
//
//  channel   ports                                            handshake
//  --------  -----------------------------------------------  ----------------------
//  request   operation_i from_index_i symbol_index_i          start & !busy
//            target_mask_i
//  result    row_index_o source_mask_o next_mask_0..3_o       done_o, one cycle
//            last_row_o nothing_queued_o
//  config    cfg_index_i cfg_wdata_i                          cfg_we_i, no wait
//
//  load, begin and no-op requests are taken at once and never raise busy
//  expand runs from its accepting edge to the edge that takes the result, with one row read
//  per nfa state and symbol plus the look-up through the set store; done_o rises as busy
//  falls; an empty queue answers next cycle
//  reset clears control and config, then a pass over every map entry zeroes the subset
//  map with busy high; row and found-set memories hold junk until written
//  results cannot be stalled: done_o lasts one cycle and outputs hold until the next expand is taken
`default_nettype none
`include "assert_macros.svh"

module nfa_subset_construction #(
  parameter int MAX_NFA_STATES = nsc_pkg::MAX_NFA_STATES_DEF,
  parameter int MAX_SYMBOLS    = nsc_pkg::MAX_SYMBOLS_DEF,
  parameter int MAX_DFA_STATES = nsc_pkg::MAX_DFA_STATES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [nsc_pkg::OP_W-1:0]      operation_i,
  input  wire logic [nsc_pkg::FROM_W-1:0]    from_index_i,
  input  wire logic [nsc_pkg::SYM_W-1:0]     symbol_index_i,
  input  wire logic [nsc_pkg::MASK_W-1:0]    target_mask_i,
  // result channel
  output logic                               done_o,
  output logic [nsc_pkg::ROW_IDX_W-1:0]      row_index_o,
  output logic [nsc_pkg::MASK_W-1:0]         source_mask_o,
  output logic [nsc_pkg::MASK_W-1:0]         next_mask_0_o,
  output logic [nsc_pkg::MASK_W-1:0]         next_mask_1_o,
  output logic [nsc_pkg::MASK_W-1:0]         next_mask_2_o,
  output logic [nsc_pkg::MASK_W-1:0]         next_mask_3_o,
  output logic                               last_row_o,
  output logic                               nothing_queued_o,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [nsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [nsc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import nsc_pkg::*;

  localparam int NS  = MAX_NFA_STATES;
  localparam int FW  = $clog2(NS);                                 // nfa state index
  localparam int SW  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1; // symbol index
  localparam int RAW = FW + SW;                                    // row memory address
  localparam int IW  = $clog2(MAX_DFA_STATES);                     // found-set index
  localparam int CW  = $clog2(MAX_DFA_STATES + 1);                 // counts up to full

  typedef enum logic [3:0] {
    ST_CLEAR,    // after reset: zero the subset map one entry per cycle
    ST_IDLE,
    ST_SRC,      // source subset arrives from the set store
    ST_GATHER,   // one row read per nfa state for the current symbol
    ST_DRAIN,    // last row folds into the accumulator
    ST_LOOKUP,   // map read at the destination subset
    ST_VERIFY,   // list read at the index the map gave
    ST_INSERT,   // decide seen or new, record the destination
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [NS-1:0]   clr_q;
  logic [3:0]      state_cnt_q;
  logic [2:0]      sym_cnt_q;
  logic [2:0]      start_idx_q;
  logic [CW-1:0]   head_q;
  logic [CW-1:0]   count_q;
  logic [NS-1:0]   src_q;
  logic [FW-1:0]   s_q;
  logic [SW-1:0]   j_q;

  logic                  done_q;
  logic [ROW_IDX_W-1:0]  row_index_q;
  logic [MASK_W-1:0]     source_mask_q;
  logic [MASK_W-1:0]     next_q [OUT_SYMS];
  logic                  last_q;
  logic                  nothing_q;

  nsc_op_e        op_in;
  logic           accept;
  logic [4:0]     live_n;
  logic [NS-1:0]  live;
  logic [3:0]     nsym;
  logic [NS-1:0]  start_set;
  logic [NS-1:0]  acc;
  logic [NS-1:0]  dest;
  logic           hit;
  logic           room;
  logic           insert;
  logic           more_syms;

  logic           row_we;
  logic [RAW-1:0] row_waddr;
  logic [RAW-1:0] row_raddr;
  acc_ctrl_t      acc_ctrl;

  logic           fs_we;
  logic [IW-1:0]  fs_waddr;
  logic [NS-1:0]  fs_wdata;
  logic [IW-1:0]  fs_raddr;
  logic [NS-1:0]  fs_rdata;
  logic           sm_we;
  logic [NS-1:0]  sm_waddr;
  logic [IW-1:0]  sm_wdata;
  logic [IW-1:0]  sm_rdata;

  assign op_in  = nsc_op_e'(operation_i);
  assign accept = start && (state_q == ST_IDLE);

  // states in use, clamped to the store size
  always_comb begin
    live_n = ({1'b0, state_cnt_q} > 5'(NS)) ? 5'(NS) : {1'b0, state_cnt_q};
    for (int i = 0; i < NS; i++) begin
      live[i]      = 5'(i) < live_n;
      start_set[i] = (5'(start_idx_q) == 5'(i)) && live[i];
    end
  end

  // symbols in use, clamped to the store size
  assign nsym = ({1'b0, sym_cnt_q} > 4'(MAX_SYMBOLS)) ? 4'(MAX_SYMBOLS) : {1'b0, sym_cnt_q};

  assign dest      = acc & live;
  assign more_syms = (4'(j_q) + 4'd1) < nsym;

  // the map entry counts only if it points inside the list and the list points back
  assign hit    = (CW'(sm_rdata) < count_q) && (fs_rdata == dest);
  assign room   = count_q < CW'(MAX_DFA_STATES);
  assign insert = (state_q == ST_INSERT) && !hit && room;

  // row memory: loads in range only
  always_comb begin
    row_we    = accept && (op_in == OP_LOAD)
                && (5'(from_index_i) < 5'(NS))
                && (4'(symbol_index_i) < 4'(MAX_SYMBOLS));
    row_waddr = {FW'(from_index_i), SW'(symbol_index_i)};
    row_raddr = {s_q, j_q};
    acc_ctrl.clear  = (state_q == ST_SRC) || (state_q == ST_INSERT);
    acc_ctrl.issue  = (state_q == ST_GATHER);
    acc_ctrl.member = src_q[s_q];
  end

  // set store: clearing pass zeroes the map, begin seeds entry zero, insert appends
  always_comb begin
    if (state_q == ST_CLEAR) begin
      fs_we    = 1'b0;
      fs_waddr = '0;
      fs_wdata = '0;
      sm_we    = 1'b1;
      sm_waddr = clr_q;
      sm_wdata = '0;
    end else if (accept && (op_in == OP_BEGIN)) begin
      fs_we    = 1'b1;
      fs_waddr = '0;
      fs_wdata = start_set;
      sm_we    = 1'b1;
      sm_waddr = start_set;
      sm_wdata = '0;
    end else begin
      fs_we    = insert;
      fs_waddr = count_q[IW-1:0];
      fs_wdata = dest;
      sm_we    = insert;
      sm_waddr = dest;
      sm_wdata = count_q[IW-1:0];
    end
    // the list is read at the queue head while idle, at the mapped index to verify
    fs_raddr = (state_q == ST_VERIFY) ? sm_rdata : head_q[IW-1:0];
  end

  nsc_row_unit #(
    .SET_W  (NS),
    .ADDR_W (RAW)
  ) u_row_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (row_we),
    .wr_addr_i (row_waddr),
    .wr_data_i (NS'(target_mask_i)),
    .rd_addr_i (row_raddr),
    .ctrl_i    (acc_ctrl),
    .acc_o     (acc)
  );

  nsc_set_store #(
    .SET_W (NS),
    .IDX_W (IW),
    .DEPTH (MAX_DFA_STATES)
  ) u_set_store (
    .clk_i      (clk_i),
    .fs_we_i    (fs_we),
    .fs_waddr_i (fs_waddr),
    .fs_wdata_i (fs_wdata),
    .fs_raddr_i (fs_raddr),
    .fs_rdata_o (fs_rdata),
    .sm_we_i    (sm_we),
    .sm_waddr_i (sm_waddr),
    .sm_wdata_i (sm_wdata),
    .sm_raddr_i (dest),
    .sm_rdata_o (sm_rdata)
  );

  // sequencer, config registers and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      state_cnt_q   <= STATE_COUNT_RST;
      sym_cnt_q     <= SYMBOL_COUNT_RST;
      start_idx_q   <= START_INDEX_RST;
      head_q        <= '0;
      count_q       <= '0;
      src_q         <= '0;
      s_q           <= '0;
      j_q           <= '0;
      done_q        <= 1'b0;
      row_index_q   <= '0;
      source_mask_q <= '0;
      for (int k = 0; k < OUT_SYMS; k++) begin
        next_q[k] <= '0;
      end
      last_q        <= 1'b0;
      nothing_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_STATE_COUNT:  state_cnt_q <= cfg_wdata_i[3:0];
          REG_SYMBOL_COUNT: sym_cnt_q   <= cfg_wdata_i[2:0];
          REG_START_INDEX:  start_idx_q <= cfg_wdata_i[2:0];
          default: ;
        endcase
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            unique case (op_in)
              OP_LOAD: ;
              OP_BEGIN: begin
                // fresh construction: only the start set is known
                head_q  <= '0;
                count_q <= CW'(1);
              end
              OP_EXPAND: begin
                if (head_q >= count_q) begin
                  // queue empty: answer at once with a zero row and masks, last and nothing-queued set
                  row_index_q   <= '0;
                  source_mask_q <= '0;
                  for (int k = 0; k < OUT_SYMS; k++) begin
                    next_q[k] <= '0;
                  end
                  last_q    <= 1'b1;
                  nothing_q <= 1'b1;
                  done_q    <= 1'b1;
                end else begin
                  row_index_q <= ROW_IDX_W'(head_q);
                  state_q     <= ST_SRC;
                end
              end
              OP_NOP: ;
              default: ;
            endcase
          end
        end
        ST_SRC: begin
          src_q         <= fs_rdata;
          source_mask_q <= MASK_W'(fs_rdata);
          head_q        <= head_q + 1'b1;
          for (int k = 0; k < OUT_SYMS; k++) begin
            next_q[k] <= '0;
          end
          nothing_q <= 1'b0;
          s_q       <= '0;
          j_q       <= '0;
          state_q   <= (nsym == 4'd0) ? ST_DONE : ST_GATHER;
        end
        ST_GATHER: begin
          s_q <= s_q + 1'b1;
          if (s_q == FW'(NS - 1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN:  state_q <= ST_LOOKUP;
        ST_LOOKUP: state_q <= ST_VERIFY;
        ST_VERIFY: state_q <= ST_INSERT;
        ST_INSERT: begin
          if (insert) begin
            count_q <= count_q + 1'b1;
          end
          for (int k = 0; k < OUT_SYMS; k++) begin
            if (4'(j_q) == 4'(k)) begin
              next_q[k] <= MASK_W'(dest);
            end
          end
          if (more_syms) begin
            j_q     <= j_q + 1'b1;
            s_q     <= '0;
            state_q <= ST_GATHER;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // counts already hold this row's inserts
          last_q  <= head_q >= count_q;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign row_index_o      = row_index_q;
  assign source_mask_o    = source_mask_q;
  assign next_mask_0_o    = next_q[0];
  assign next_mask_1_o    = next_q[1];
  assign next_mask_2_o    = next_q[2];
  assign next_mask_3_o    = next_q[3];
  assign last_row_o       = last_q;
  assign nothing_queued_o = nothing_q;

  `NSC_ASSERT(a_head_le_count, head_q <= count_q, "queue head ran past the found count")
  `NSC_ASSERT(a_count_le_max, count_q <= CW'(MAX_DFA_STATES), "found count beyond store")
  `NSC_ASSERT(a_strobe_when_idle, done_q |-> (state_q == ST_IDLE), "result shown while busy")
  `NSC_ASSERT_ALWAYS(a_clear_in_reset, !rst_ni |-> (state_q == ST_CLEAR), "no map clear in reset")

endmodule

`default_nettype wire

>>> dv/nsc_checker.sv
// checker of the subset construction block: predicts each expand result and compares it
module nsc_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               busy_i,
  input  logic [nsc_pkg::OP_W-1:0]           operation_i,
  input  logic [nsc_pkg::FROM_W-1:0]         from_index_i,
  input  logic [nsc_pkg::SYM_W-1:0]          symbol_index_i,
  input  logic [nsc_pkg::MASK_W-1:0]         target_mask_i,
  input  logic                               done_i,
  input  logic [nsc_pkg::ROW_IDX_W-1:0]      row_index_i,
  input  logic [nsc_pkg::MASK_W-1:0]         source_mask_i,
  input  logic [nsc_pkg::MASK_W-1:0]         next_mask_0_i,
  input  logic [nsc_pkg::MASK_W-1:0]         next_mask_1_i,
  input  logic [nsc_pkg::MASK_W-1:0]         next_mask_2_i,
  input  logic [nsc_pkg::MASK_W-1:0]         next_mask_3_i,
  input  logic                               last_row_i,
  input  logic                               nothing_queued_i,
  input  logic                               cfg_we_i,
  input  logic [nsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [nsc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output int unsigned                        pending_o,
  output int unsigned                        fail_count_o
);
  import nsc_pkg::*;

  localparam int NFA_ROWS    = MAX_NFA_STATES_DEF * MAX_SYMBOLS_DEF;
  localparam int SUBSETS     = 1 << MAX_NFA_STATES_DEF;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [ROW_IDX_W-1:0]             row;
    logic [MASK_W-1:0]                src;
    logic [OUT_SYMS-1:0][MASK_W-1:0]  dest;
    logic                             last;
    logic                             empty_q;
  } dfa_row_t;

  logic [MASK_W-1:0] nfa_table [NFA_ROWS];
  logic [MASK_W-1:0] found_list [MAX_DFA_STATES_DEF];
  bit                seen [SUBSETS];
  int unsigned       head = 0;
  int unsigned       found = 0;
  logic [3:0]        n_states = STATE_COUNT_RST;
  logic [2:0]        n_syms = SYMBOL_COUNT_RST;
  logic [2:0]        first_state = START_INDEX_RST;
  dfa_row_t          rows_due [$];
  int unsigned       errors = 0;

  function automatic logic [MASK_W-1:0] live_states();
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_NFA_STATES_DEF; i++)
      if (i < n_states) m[i] = 1'b1;
    return m;
  endfunction

  task automatic add_subset(input logic [MASK_W-1:0] s);
    if (!seen[s] && found < MAX_DFA_STATES_DEF) begin
      seen[s] = 1'b1;
      found_list[found] = s;
      found++;
    end
  endtask

  task automatic expand_next(output dfa_row_t r);
    logic [MASK_W-1:0] live, src, acc;
    int unsigned       nsym;
    live = live_states();
    nsym = (n_syms > MAX_SYMBOLS_DEF) ? MAX_SYMBOLS_DEF : n_syms;
    r = '0;
    if (head >= found) begin
      r.last = 1'b1;
      r.empty_q = 1'b1;
      return;
    end
    src = found_list[head];
    r.row = ROW_IDX_W'(head);
    r.src = src;
    head++;
    for (int j = 0; j < nsym; j++) begin
      acc = '0;
      for (int s = 0; s < MAX_NFA_STATES_DEF; s++)
        if (src[s]) acc |= nfa_table[s * MAX_SYMBOLS_DEF + j];
      acc &= live;
      if (j < OUT_SYMS) r.dest[j] = acc;
      add_subset(acc);
    end
    r.last = (head >= found);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    dfa_row_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < NFA_ROWS; i++) nfa_table[i] = '0;
      for (int i = 0; i < SUBSETS; i++) seen[i] = 1'b0;
      head = 0;
      found = 0;
      n_states = STATE_COUNT_RST;
      n_syms = SYMBOL_COUNT_RST;
      first_state = START_INDEX_RST;
      rows_due.delete();
    end else begin
      // results first, so a request taken at the same edge never pairs with them
      if (done_i) begin
        got.row = row_index_i;
        got.src = source_mask_i;
        got.dest[0] = next_mask_0_i;
        got.dest[1] = next_mask_1_i;
        got.dest[2] = next_mask_2_i;
        got.dest[3] = next_mask_3_i;
        got.last = last_row_i;
        got.empty_q = nothing_queued_i;
        if (rows_due.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: result with no request outstanding", $time);
          errors++;
        end else begin
          want = rows_due.pop_front();
          check_field("row_index", want.row, got.row);
          check_field("source_mask", want.src, got.src);
          for (int j = 0; j < OUT_SYMS; j++)
            check_field($sformatf("next_mask_%0d", j), want.dest[j], got.dest[j]);
          check_field("last_row", want.last, got.last);
          check_field("nothing_queued", want.empty_q, got.empty_q);
        end
      end
      if (start_i && !busy_i) begin
        case (nsc_op_e'(operation_i))
          OP_LOAD:
            nfa_table[from_index_i * MAX_SYMBOLS_DEF + symbol_index_i] = target_mask_i;
          OP_BEGIN: begin
            for (int i = 0; i < SUBSETS; i++) seen[i] = 1'b0;
            head = 0;
            found = 0;
            add_subset((MASK_W'(1) << first_state) & live_states());
          end
          OP_EXPAND: begin
            expand_next(want);
            rows_due = {rows_due, want};
          end
          default: ;
        endcase
      end
      // register writes land after any request of the same edge
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_STATE_COUNT:  n_states = cfg_wdata_i;
          REG_SYMBOL_COUNT: n_syms = cfg_wdata_i[2:0];
          REG_START_INDEX:  first_state = cfg_wdata_i[2:0];
          default: ;
        endcase
      end
    end
    pending_o <= rows_due.size();
    fail_count_o <= errors;
  end

endmodule

>>> dv/tb_top.sv
// testbench top of the subset construction block: clock, reset, stimulus and verdict
module tb_top;
  import nsc_pkg::*;

  localparam int ITEM_TARGET   = 1950;
  // settle time, longer than the longest expand
  localparam int SETTLE_CYCLES = 64;
  // cycles with no handshake at all before the run is declared hung
  localparam int STALL_LIMIT   = 2000;
  // expands per construction before a fresh begin cuts it short
  localparam int RUN_CAP       = 48;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [OP_W-1:0]       operation_i;
  logic [FROM_W-1:0]     from_index_i;
  logic [SYM_W-1:0]      symbol_index_i;
  logic [MASK_W-1:0]     target_mask_i;
  logic                  done_o;
  logic [ROW_IDX_W-1:0]  row_index_o;
  logic [MASK_W-1:0]     source_mask_o;
  logic [MASK_W-1:0]     next_mask_0_o;
  logic [MASK_W-1:0]     next_mask_1_o;
  logic [MASK_W-1:0]     next_mask_2_o;
  logic [MASK_W-1:0]     next_mask_3_o;
  logic                  last_row_o;
  logic                  nothing_queued_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned sent_items = 0;
  int unsigned drained_runs = 0;
  int unsigned stall_cycles = 0;
  bit          pace_gaps = 1'b1;

  nfa_subset_construction DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .from_index_i     (from_index_i),
    .symbol_index_i   (symbol_index_i),
    .target_mask_i    (target_mask_i),
    .done_o           (done_o),
    .row_index_o      (row_index_o),
    .source_mask_o    (source_mask_o),
    .next_mask_0_o    (next_mask_0_o),
    .next_mask_1_o    (next_mask_1_o),
    .next_mask_2_o    (next_mask_2_o),
    .next_mask_3_o    (next_mask_3_o),
    .last_row_o       (last_row_o),
    .nothing_queued_o (nothing_queued_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  nsc_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .operation_i      (operation_i),
    .from_index_i     (from_index_i),
    .symbol_index_i   (symbol_index_i),
    .target_mask_i    (target_mask_i),
    .done_i           (done_o),
    .row_index_i      (row_index_o),
    .source_mask_i    (source_mask_o),
    .next_mask_0_i    (next_mask_0_o),
    .next_mask_1_i    (next_mask_1_o),
    .next_mask_2_i    (next_mask_2_o),
    .next_mask_3_i    (next_mask_3_o),
    .last_row_i       (last_row_o),
    .nothing_queued_i (nothing_queued_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pending_o        (pending),
    .fail_count_o     (fail_count)
  );

  // 8 time unit clock, first rising edge at 4
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // counts constructions that ran dry, so a run knows when to stop expanding
  always @(posedge clk_i) begin
    if (done_o && last_row_o) drained_runs <= drained_runs + 1;
  end

  // watchdog: any accepted request, result or register write restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // sparse masks dominate so that constructions find many distinct subsets
  function automatic logic [MASK_W-1:0] pick_targets();
    case ($urandom_range(0, 4))
      0: return MASK_W'($urandom_range(0, 255));
      1: return MASK_W'(1) << $urandom_range(0, 7);
      2: return MASK_W'($urandom_range(0, 255) & $urandom_range(0, 255));
      3: return $urandom_range(0, 1) ? '1 : '0;
      default: return (MASK_W'(1) << $urandom_range(0, 7)) | (MASK_W'(1) << $urandom_range(0, 7));
    endcase
  endfunction

  // state count leans to 2..8, with zero, one, eight and the clipped values too
  function automatic logic [CFG_DATA_W-1:0] pick_state_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DATA_W'($urandom_range(9, 15));
      2: return CFG_DATA_W'(1);
      3: return CFG_DATA_W'(8);
      default: return CFG_DATA_W'($urandom_range(2, 8));
    endcase
  endfunction

  // one request: optional idle gap, then hold start until the block takes it
  // returns at the accepting edge with start still high
  task automatic send(input nsc_op_e op, input logic [FROM_W-1:0] src_state,
                      input logic [SYM_W-1:0] sym, input logic [MASK_W-1:0] targets);
    int unsigned gap;
    gap = pace_gaps ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    operation_i    <= op;
    from_index_i   <= src_state;
    symbol_index_i <= sym;
    target_mask_i  <= targets;
    do @(posedge clk_i); while (busy);
    if (op != OP_NOP) sent_items++;
  endtask

  // begin, expand or no-op request with junk in the unused fields
  task automatic send_plain(input nsc_op_e op);
    send(op, FROM_W'($urandom_range(0, 7)), SYM_W'($urandom_range(0, 3)),
         MASK_W'($urandom_range(0, 255)));
  endtask

  // most expands wait for their result, the rest leave the next request
  // pending while the block is still busy
  task automatic expand_once();
    send_plain(OP_EXPAND);
    if ($urandom_range(0, 3) != 0) begin
      start <= 1'b0;
      do @(posedge clk_i); while (!done_o);
    end
  endtask

  task automatic wait_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // idle point for register writes: no result owed and no expand still running
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // one construction: begin, then expand until the queue runs dry or the cap hits
  task automatic construct_run();
    int unsigned mark;
    int unsigned steps;
    wait_results();
    mark = drained_runs;
    send_plain(OP_BEGIN);
    if ($urandom_range(0, 9) == 0) send_plain(OP_BEGIN);
    steps = 0;
    while (drained_runs == mark && steps < RUN_CAP) begin
      // occasional row rewrite or no-op in the middle of a construction
      case ($urandom_range(0, 15))
        0: send(OP_LOAD, FROM_W'($urandom_range(0, 7)), SYM_W'($urandom_range(0, 3)),
                pick_targets());
        1: send_plain(OP_NOP);
        default: ;
      endcase
      expand_once();
      steps++;
    end
    // run past the end to hit the empty queue answer
    if ($urandom_range(0, 3) == 0) expand_once();
  endtask

  task automatic random_phase();
    logic [CFG_DATA_W-1:0] states;
    int unsigned           top_state;
    int unsigned           runs;
    settle();
    states = pick_state_count();
    top_state = (states == 0) ? 0 : (states > 8) ? 7 : states - 1;
    write_reg(REG_STATE_COUNT, states);
    write_reg(REG_SYMBOL_COUNT, ($urandom_range(0, 5) == 0) ?
              CFG_DATA_W'($urandom_range(0, 15)) : CFG_DATA_W'($urandom_range(1, 4)));
    // start state mostly in use, sometimes anything including out of range
    write_reg(REG_START_INDEX, ($urandom_range(0, 3) == 0) ?
              CFG_DATA_W'($urandom_range(0, 15)) : CFG_DATA_W'($urandom_range(0, top_state)));
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 15)));
    cfg_we_i <= 1'b0;
    pace_gaps = ($urandom_range(0, 3) != 0);
    // fresh rows now and then so constructions differ from phase to phase
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(2, 8))
        send(OP_LOAD, FROM_W'($urandom_range(0, 7)), SYM_W'($urandom_range(0, 3)),
             pick_targets());
    end
    // broken sequence: stray expands on a drained or cut-off queue
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) send_plain(OP_EXPAND);
    end
    runs = $urandom_range(1, 4);
    repeat (runs) construct_run();
  endtask

  initial begin
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    operation_i    <= OP_NOP;
    from_index_i   <= '0;
    symbol_index_i <= '0;
    target_mask_i  <= '0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= REG_STATE_COUNT;
    cfg_wdata_i    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // expand before any begin, then a no-op
    send_plain(OP_EXPAND);
    send(OP_NOP, 3'd7, 2'd3, 8'hFF);

    // two states, two symbols: start {0}, rows give {0,1} and the dead set
    settle();
    write_reg(REG_STATE_COUNT, 4'd2);
    write_reg(REG_SYMBOL_COUNT, 4'd2);
    write_reg(REG_START_INDEX, 4'd0);
    cfg_we_i <= 1'b0;
    send(OP_LOAD, 3'd0, 2'd0, 8'hFF);   // bits above the state count drop out
    send(OP_LOAD, 3'd0, 2'd1, 8'h00);
    send(OP_LOAD, 3'd1, 2'd0, 8'h02);
    send(OP_LOAD, 3'd1, 2'd1, 8'h01);
    send(OP_LOAD, 3'd7, 2'd3, 8'hFF);   // top corner of the row store
    send_plain(OP_BEGIN);
    repeat (4) send_plain(OP_EXPAND);   // three rows, last one dead, then empty

    // start state beyond the state count gives the empty start set
    settle();
    write_reg(REG_START_INDEX, 4'd5);
    cfg_we_i <= 1'b0;
    send_plain(OP_BEGIN);
    repeat (2) send_plain(OP_EXPAND);

    // no states and no symbols at all
    settle();
    write_reg(REG_STATE_COUNT, 4'd0);
    write_reg(REG_SYMBOL_COUNT, 4'd0);
    write_reg(REG_START_INDEX, 4'd0);
    cfg_we_i <= 1'b0;
    send_plain(OP_BEGIN);
    repeat (2) send_plain(OP_EXPAND);

    // fill the whole row store so that no expand can read an unwritten row
    for (int s = 0; s < MAX_NFA_STATES_DEF; s++)
      for (int j = 0; j < MAX_SYMBOLS_DEF; j++)
        send(OP_LOAD, FROM_W'(s), SYM_W'(j), pick_targets());

    while (sent_items < ITEM_TARGET) random_phase();

    // drain and give a late stray result time to show up
    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
